// ===== hdl/plt_pkg.sv =====
// shared types and constants for the palette learn and nearest match block
package plt_pkg;

    // command codes carried in tuser
    localparam logic CMD_LEARN = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    // field widths of a result
    localparam int unsigned DIST_W    = 10;
    localparam int unsigned IDX_OUT_W = 8;
    localparam int unsigned USED_OUT_W = 9;

    // starting best distance, 255 * 3
    localparam logic [DIST_W-1:0] DIST_START = 10'd765;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    // control group that walks the cell row with an item
    typedef struct packed {
        logic valid;
        logic cmd;
        logic found;
    } t_ctrl;

    typedef struct packed {
        logic [USED_OUT_W-1:0] entries_used;
        logic                  dropped_full;
        logic                  already_present;
        logic [DIST_W-1:0]     best_distance;
        logic [IDX_OUT_W-1:0]  color_index;
    } t_result;

endpackage

// ===== hdl/plt_cell.sv =====
// one palette cell: holds one color and updates the passing item
module plt_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned IW    = 8,
    parameter int unsigned CW    = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  plt_pkg::t_ctrl             i_ctl,
    input  plt_pkg::t_rgb              i_rgb,
    input  logic [plt_pkg::DIST_W-1:0] i_best,
    input  logic [IW-1:0]              i_idx,
    input  logic [CW-1:0]              i_used,
    output plt_pkg::t_ctrl             o_ctl,
    output plt_pkg::t_rgb              o_rgb,
    output logic [plt_pkg::DIST_W-1:0] o_best,
    output logic [IW-1:0]              o_idx,
    output logic [CW-1:0]              o_used
);
    import plt_pkg::*;

    localparam logic [CW-1:0] K_SLOT = CW'(INDEX);
    localparam logic [IW-1:0] K_IDX  = IW'(INDEX);

    t_rgb              r_entry;
    t_ctrl             r_ctl;
    t_rgb              r_rgb;
    logic [DIST_W-1:0] r_best;
    logic [IW-1:0]     r_idx;
    logic [CW-1:0]     r_used;

    t_ctrl             n_ctl;
    logic [DIST_W-1:0] n_best;
    logic [IW-1:0]     n_idx;
    logic              s_write;
    logic              s_in_use;
    logic [7:0]        s_dr;
    logic [7:0]        s_dg;
    logic [7:0]        s_db;
    logic [DIST_W-1:0] s_dist;

    // manhattan distance to the held color
    always_comb begin
        s_dr   = (i_rgb.red > r_entry.red) ? (i_rgb.red - r_entry.red)
                                           : (r_entry.red - i_rgb.red);
        s_dg   = (i_rgb.green > r_entry.green) ? (i_rgb.green - r_entry.green)
                                               : (r_entry.green - i_rgb.green);
        s_db   = (i_rgb.blue > r_entry.blue) ? (i_rgb.blue - r_entry.blue)
                                             : (r_entry.blue - i_rgb.blue);
        s_dist = DIST_W'(s_dr) + DIST_W'(s_dg) + DIST_W'(s_db);
    end

    // update of the passing item
    always_comb begin
        s_in_use = K_SLOT < i_used;
        n_ctl    = i_ctl;
        n_best   = i_best;
        n_idx    = i_idx;
        s_write  = 1'b0;
        if (i_ctl.valid) begin
            if (i_ctl.cmd == CMD_MATCH) begin
                if (s_in_use && (s_dist < i_best)) begin
                    n_best = s_dist;
                    n_idx  = K_IDX;
                end
            end else begin
                if (s_in_use && !i_ctl.found && (r_entry == i_rgb)) begin
                    n_ctl.found = 1'b1;
                    n_idx       = K_IDX;
                end
                // first free slot, all used slots already checked
                if ((K_SLOT == i_used) && !i_ctl.found) begin
                    s_write = 1'b1;
                end
            end
        end
    end

    // item control flags: valid, cmd and found
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // stored color and item payload
    always_ff @(posedge i_clk) begin
        if (s_write) begin
            r_entry <= i_rgb;
        end
        r_rgb  <= i_rgb;
        r_best <= n_best;
        r_idx  <= n_idx;
        r_used <= i_used;
    end

    assign o_ctl  = r_ctl;
    assign o_rgb  = r_rgb;
    assign o_best = r_best;
    assign o_idx  = r_idx;
    assign o_used = r_used;

endmodule

// ===== hdl/palette_learn_and_nearest_match_top.sv =====
// palette learn and nearest match: row of color cells with result registers
// an accepted item passes through the register of every cell, then the output register
// one item at a time: a new item is taken once the last has left the row and the skid is empty
// a finished result waits in an output register plus one skid register
// reset (synchronous, i_rst_n low) clears the entry count and all valid flags;
// cells beyond the count are never compared, so no clearing pass is needed
module palette_learn_and_nearest_match_top #(
    parameter int unsigned ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // red[7:0], green[15:8], blue[23:16]
    input  logic        i_s_tuser,  // cmd[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // color_index[7:0], best_distance[17:8], already_present[18],
    // dropped_full[19], entries_used[28:20], zero[31:29]
    output logic [31:0] o_m_tdata
);
    import plt_pkg::*;

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    t_ctrl             s_ctl  [0:ENTRIES];
    t_rgb              s_rgb  [0:ENTRIES];
    logic [DIST_W-1:0] s_best [0:ENTRIES];
    logic [IW-1:0]     s_idx  [0:ENTRIES];
    logic [CW-1:0]     s_used [0:ENTRIES];

    logic              r_busy;
    logic [CW-1:0]     r_used;
    logic              r_out_valid;
    logic              r_skid_valid;
    t_result           r_out;
    t_result           r_skid;

    logic              s_accept;
    logic              s_take;
    logic              s_fin;
    logic              s_room;
    t_result           s_res;
    logic [CW-1:0]     n_used;
    logic [IW-1:0]     s_fidx;
    logic [IW+IDX_OUT_W-1:0]  s_idx_ext;
    logic [CW+USED_OUT_W-1:0] s_used_ext;

    assign o_s_tready = !r_busy && !r_skid_valid;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_take     = r_out_valid && i_m_tready;
    assign s_fin      = s_ctl[ENTRIES].valid;

    // item enters the first cell
    always_comb begin
        s_ctl[0].valid = s_accept;
        s_ctl[0].cmd   = i_s_tuser;
        s_ctl[0].found = 1'b0;
        s_rgb[0].red   = i_s_tdata[7:0];
        s_rgb[0].green = i_s_tdata[15:8];
        s_rgb[0].blue  = i_s_tdata[23:16];
        s_best[0]      = DIST_START;
        s_idx[0]       = '0;
        s_used[0]      = r_used;
    end

    // row of palette cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        plt_cell #(
            .INDEX (g),
            .IW    (IW),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[g]),
            .i_rgb   (s_rgb[g]),
            .i_best  (s_best[g]),
            .i_idx   (s_idx[g]),
            .i_used  (s_used[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_rgb   (s_rgb[g+1]),
            .o_best  (s_best[g+1]),
            .o_idx   (s_idx[g+1]),
            .o_used  (s_used[g+1])
        );
    end

    // result of the item leaving the last cell
    always_comb begin
        s_room = s_used[ENTRIES] < CW'(ENTRIES);
        n_used = s_used[ENTRIES];
        s_fidx = s_idx[ENTRIES];
        s_res  = '0;
        if (s_ctl[ENTRIES].cmd == CMD_MATCH) begin
            s_res.best_distance = s_best[ENTRIES];
        end else if (s_ctl[ENTRIES].found) begin
            s_res.already_present = 1'b1;
        end else if (s_room) begin
            s_fidx = s_used[ENTRIES][IW-1:0];
            n_used = s_used[ENTRIES] + CW'(1);
        end else begin
            s_res.dropped_full = 1'b1;
            s_fidx             = '0;
        end
        s_idx_ext          = {{IDX_OUT_W{1'b0}}, s_fidx};
        s_used_ext         = {{USED_OUT_W{1'b0}}, n_used};
        s_res.color_index  = s_idx_ext[IDX_OUT_W-1:0];
        s_res.entries_used = s_used_ext[USED_OUT_W-1:0];
    end

    // control: busy flag, entry count, output and skid valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_busy <= 1'b1;
            end else if (s_fin) begin
                r_busy <= 1'b0;
            end
            if (s_fin) begin
                r_used <= n_used;
                if (!r_out_valid || s_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (s_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        if (s_fin) begin
            if (!r_out_valid || s_take) begin
                r_out <= s_res;
            end else begin
                r_skid <= s_res;
            end
        end else if (s_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out};

endmodule

// ===== hdl/plt_checker.sv =====
// port-level checks for the palette learn and nearest match block
module plt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);
    // stalled result holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // one item in flight: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in flight");

    // distance never above the starting best
    a_dist_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[17:8] <= 10'd765))
        else $error("distance above start value");

    // a dropped color is not also present, and points at slot zero
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[19]) |-> (!o_m_tdata[18] && (o_m_tdata[7:0] == 8'd0)))
        else $error("inconsistent drop flags");

endmodule

bind palette_learn_and_nearest_match_top plt_checker u_plt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/palette_learn_and_nearest_match_top_test.sv =====
// self-checking testbench for the palette learn and nearest match block
module palette_learn_and_nearest_match_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plt_pkg::*;

    localparam int unsigned PAL_ENTRIES  = 256;
    localparam int unsigned LATENCY      = PAL_ENTRIES + 1;
    localparam int unsigned DIRECTED_N   = 20;
    localparam int unsigned RANDOM_ITEMS = 1830;
    localparam int unsigned LONG_HOLD    = 1500;
    localparam int unsigned CYCLE_LIMIT  = 3000000;

    // one row of the directed table, typed expectation used only when typed is set
    typedef struct packed {
        logic       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         typed;
        logic [7:0] w_idx;
        logic [9:0] w_dist;
        logic       w_pres;
        logic       w_drop;
        logic [8:0] w_used;
    } t_stim_row;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // red[7:0], green[15:8], blue[23:16]
    logic        s_tuser  = 1'b0;  // cmd[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // color_index[7:0], best_distance[17:8], already_present[18],
    // dropped_full[19], entries_used[28:20], zero[31:29]
    logic [31:0] m_tdata;

    // palette mirror and outstanding results
    t_rgb        pal_colors [PAL_ENTRIES];
    int unsigned pal_used     = 0;
    t_result     pal_expect [$];
    int unsigned results_seen = 0;
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    bit          calm         = 1'b0;

    t_stim_row   directed_rows [DIRECTED_N];

    palette_learn_and_nearest_match_top #(
        .ENTRIES(PAL_ENTRIES)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned chan_gap(logic [7:0] a, logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // palette behavior for one accepted pixel, updates the mirror
    function automatic t_result predict_palette(logic cmd, t_rgb px);
        t_result     res;
        int unsigned k;
        int unsigned best;
        int unsigned d;
        bit          hit;
        res = '0;
        hit = 1'b0;
        if (cmd == CMD_LEARN) begin
            // lowest matching slot among the used ones
            for (k = 0; k < pal_used && !hit; k++) begin
                if (pal_colors[k] == px) begin
                    hit = 1'b1;
                    res.color_index = 8'(k);
                end
            end
            if (hit) begin
                res.already_present = 1'b1;
            end else if (pal_used < PAL_ENTRIES) begin
                pal_colors[pal_used] = px;
                res.color_index = 8'(pal_used);
                pal_used++;
            end else begin
                res.dropped_full = 1'b1;
            end
        end else begin
            // strictly smaller distance wins, so ties keep the lower index
            best = DIST_START;
            for (k = 0; k < pal_used; k++) begin
                d = chan_gap(px.red, pal_colors[k].red)
                  + chan_gap(px.green, pal_colors[k].green)
                  + chan_gap(px.blue, pal_colors[k].blue);
                if (d < best) begin
                    best = d;
                    res.color_index = 8'(k);
                end
            end
            res.best_distance = DIST_W'(best);
        end
        res.entries_used = USED_OUT_W'(pal_used);
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_rgb random_rgb();
        t_rgb px;
        px.red   = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue  = 8'($urandom_range(0, 255));
        return px;
    endfunction

    // small random offset, clamped to the channel range
    function automatic logic [7:0] nudge(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        else if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // learns fill the palette, matches aim near stored colors
    task automatic pick_item(output logic cmd, output t_rgb px);
        int unsigned roll;
        t_rgb        seen;
        if (pal_used != 0) seen = pal_colors[$urandom_range(0, pal_used - 1)];
        else seen = random_rgb();
        if ($urandom_range(0, 99) < 45) begin
            cmd = CMD_LEARN;
            px = ($urandom_range(0, 3) == 0) ? seen : random_rgb();
        end else begin
            cmd = CMD_MATCH;
            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                px = random_rgb();
            end else if (roll < 8) begin
                px.red   = nudge(seen.red);
                px.green = nudge(seen.green);
                px.blue  = nudge(seen.blue);
            end else if (roll < 9) begin
                px = seen;
            end else begin
                px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        end
    endtask

    // offer one pixel from a falling edge, return at the falling edge after the transfer
    task automatic send_pixel(input logic cmd, input t_rgb px, input bit typed,
                              input t_result want);
        int unsigned gap;
        t_result     calc;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        calc = predict_palette(cmd, px);
        pal_expect.push_back(typed ? want : calc);
        @(negedge clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial begin : result_sink
        int unsigned stall_left;
        bit          held_long;
        stall_left = 0;
        held_long  = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held_long && results_seen >= 40) begin
                stall_left = LONG_HOLD;
                held_long  = 1'b1;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            m_tready <= (stall_left == 0);
            if (stall_left != 0) stall_left--;
        end
    end

    // compare each result transfer with the oldest outstanding expectation
    initial begin : result_check
        t_result got;
        t_result want;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                got = m_tdata[28:0];
                results_seen++;
                if (pal_expect.size() == 0) begin
                    $error("result with no item outstanding: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pal_expect.pop_front();
                    check_field("color_index", want.color_index, got.color_index);
                    check_field("best_distance", want.best_distance, got.best_distance);
                    check_field("already_present", want.already_present,
                                got.already_present);
                    check_field("dropped_full", want.dropped_full, got.dropped_full);
                    check_field("entries_used", want.entries_used, got.entries_used);
                    check_field("pad", 0, m_tdata[31:29]);
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic    cmd;
        t_rgb    px;
        t_result want;
        int      n;

        foreach (pal_colors[k]) pal_colors[k] = '0;

        // cmd, r, g, b, typed, idx, dist, present, dropped, used
        directed_rows = '{
            // empty palette
            '{CMD_MATCH, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0, DIST_START, 1'b0, 1'b0, 9'd0},
            '{CMD_MATCH, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, DIST_START, 1'b0, 1'b0, 9'd0},
            '{CMD_LEARN, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 10'd0,      1'b0, 1'b0, 9'd1},
            // only entry sits at the full start distance
            '{CMD_MATCH, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, DIST_START, 1'b0, 1'b0, 9'd1},
            '{CMD_MATCH, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 10'd0,      1'b0, 1'b0, 9'd1},
            // duplicate learn
            '{CMD_LEARN, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 10'd0,      1'b1, 1'b0, 9'd1},
            '{CMD_LEARN, 8'd255, 8'd255, 8'd255, 1'b1, 8'd1, 10'd0,      1'b0, 1'b0, 9'd2},
            '{CMD_MATCH, 8'd255, 8'd255, 8'd255, 1'b1, 8'd1, 10'd0,      1'b0, 1'b0, 9'd2},
            '{CMD_MATCH, 8'd128, 8'd128, 8'd128, 1'b0, 8'd0, 10'd0,      1'b0, 1'b0, 9'd0},
            '{CMD_LEARN, 8'd255, 8'd0,   8'd0,   1'b1, 8'd2, 10'd0,      1'b0, 1'b0, 9'd3},
            '{CMD_LEARN, 8'd0,   8'd255, 8'd0,   1'b1, 8'd3, 10'd0,      1'b0, 1'b0, 9'd4},
            '{CMD_LEARN, 8'd0,   8'd0,   8'd255, 1'b1, 8'd4, 10'd0,      1'b0, 1'b0, 9'd5},
            // tie between red and green entries, lower index wins
            '{CMD_MATCH, 8'd128, 8'd128, 8'd0,   1'b0, 8'd0, 10'd0,      1'b0, 1'b0, 9'd0},
            '{CMD_MATCH, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 10'd0,      1'b0, 1'b0, 9'd5},
            '{CMD_LEARN, 8'd255, 8'd0,   8'd0,   1'b1, 8'd2, 10'd0,      1'b1, 1'b0, 9'd5},
            '{CMD_MATCH, 8'hAA,  8'h55,  8'hAA,  1'b0, 8'd0, 10'd0,      1'b0, 1'b0, 9'd0},
            '{CMD_LEARN, 8'h55,  8'hAA,  8'h55,  1'b1, 8'd5, 10'd0,      1'b0, 1'b0, 9'd6},
            '{CMD_MATCH, 8'h55,  8'hAA,  8'h55,  1'b1, 8'd5, 10'd0,      1'b0, 1'b0, 9'd6},
            '{CMD_MATCH, 8'd1,   8'd1,   8'd1,   1'b1, 8'd0, 10'd3,      1'b0, 1'b0, 9'd6},
            '{CMD_MATCH, 8'd254, 8'd1,   8'd0,   1'b0, 8'd0, 10'd0,      1'b0, 1'b0, 9'd0}
        };

        // reset
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed table
        foreach (directed_rows[r]) begin
            px.red                = directed_rows[r].red;
            px.green              = directed_rows[r].green;
            px.blue               = directed_rows[r].blue;
            want.color_index      = directed_rows[r].w_idx;
            want.best_distance    = directed_rows[r].w_dist;
            want.already_present  = directed_rows[r].w_pres;
            want.dropped_full     = directed_rows[r].w_drop;
            want.entries_used     = directed_rows[r].w_used;
            send_pixel(directed_rows[r].cmd, px, directed_rows[r].typed, want);
        end

        // random pixels, with stretches of no idling
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            pick_item(cmd, px);
            send_pixel(cmd, px, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pal_expect.size() != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (fail_count == 0 && pal_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
